[hw/rtl/ede_pkg.sv]
// Package for the edit distance engine: sizes, operation codes and widths.
// No dependencies; every other file takes these by scoped name.
package ede_pkg;

    // Longest string held for either side of a pair
    localparam int MAX_LEN = 1024;

    // Counter width: holds 0..MAX_LEN
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    // Cost row address width: the row has MAX_LEN+1 cells
    localparam int ROW_AW  = LEN_W;
    // Reference store address width
    localparam int REF_AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    // Row cell width: a cost never exceeds MAX_LEN
    localparam int COST_W  = LEN_W;

    // Transaction field widths
    localparam int OP_W    = 2;
    localparam int SYM_W   = 8;
    localparam int DIST_W  = 11;

    // Operation codes of an input transaction
    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_QUERY  = 2'd1,
        OP_FINISH = 2'd2
    } t_op;

    // Result status codes
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_OVERFLOW = 1'b1;

endpackage

[hw/rtl/ede_in_if.sv]
// Input channel of the edit distance engine: operation and symbol.
// Depends on ede_pkg for the field widths.
interface ede_in_if;
    logic                       valid;
    logic                       ready;
    logic [ede_pkg::OP_W-1:0]   operation;
    logic [ede_pkg::SYM_W-1:0]  symbol;

    modport source (output valid, output operation, output symbol, input ready);
    modport sink   (input valid, input operation, input symbol, output ready);
endinterface

[hw/rtl/ede_out_if.sv]
// Result channel of the edit distance engine: distance and status.
// Depends on ede_pkg for the field widths.
interface ede_out_if;
    logic                       valid;
    logic                       ready;
    logic [ede_pkg::DIST_W-1:0] distance;
    logic                       status;

    modport source (output valid, output distance, output status, input ready);
    modport sink   (input valid, input distance, input status, output ready);
endinterface

[hw/rtl/edit_distance_engine.sv]
// Levenshtein edit distance engine: reference store, rolling cost row, cell sequencer.
// Depends on ede_pkg, ede_in_if and ede_out_if.
//
//  channel | dir | fields               | meaning
//  --------+-----+----------------------+-----------------------------------------
//  i_in    | in  | operation, symbol    | load reference / query symbol / finish
//  o_out   | out | distance, status     | one result per finish transaction
//
// A load is taken in S_IDLE. A query symbol passes S_PRIME, then S_CELL for each of the n reference symbols:
// one shared cell unit updates one row cell per cycle through the row memory port.
// A finish goes to S_FIN and waits there for the output register to drain.
// Reset is synchronous, active low, and clears counters and the flag; both
// memories need no clearing since the first query symbol seeds the row.
// Loads and queries are accepted while an earlier result waits in the output register.
module edit_distance_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ede_in_if.sink        i_in,
    ede_out_if.source     o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PRIME,
        S_CELL,
        S_FIN
    } t_state;

    // Memories
    logic [ede_pkg::SYM_W-1:0]  ref_mem [ede_pkg::MAX_LEN];
    logic [ede_pkg::COST_W-1:0] row_mem [ede_pkg::MAX_LEN+1];

    // Control and datapath registers
    t_state                     r_state;
    logic [ede_pkg::LEN_W-1:0]  r_ref_len;
    logic [ede_pkg::LEN_W-1:0]  r_qc;
    logic                       r_ovf;
    logic                       r_first;
    logic [ede_pkg::LEN_W-1:0]  r_j;
    logic [ede_pkg::SYM_W-1:0]  r_q;
    logic [ede_pkg::COST_W-1:0] r_diag;
    logic [ede_pkg::COST_W-1:0] r_left;
    logic [ede_pkg::COST_W-1:0] r_row_rd;
    logic [ede_pkg::SYM_W-1:0]  r_ref_rd;
    logic                       r_out_valid;
    logic [ede_pkg::DIST_W-1:0] r_out_dist;
    logic                       r_out_status;

    // Memory port controls
    logic [ede_pkg::ROW_AW-1:0] row_rd_addr;
    logic                       row_we;
    logic [ede_pkg::ROW_AW-1:0] row_wr_addr;
    logic [ede_pkg::COST_W-1:0] row_wr_data;
    logic [ede_pkg::REF_AW-1:0] ref_rd_addr;
    logic                       ref_we;

    logic                       in_accept;
    logic                       is_load;
    logic                       is_query;
    logic                       is_finish;
    logic                       out_free;
    logic [ede_pkg::COST_W-1:0] up;
    logic [ede_pkg::COST_W-1:0] min_du;
    logic [ede_pkg::COST_W-1:0] min_all;
    logic [ede_pkg::COST_W-1:0] cell_val;
    logic [ede_pkg::LEN_W-1:0]  qc_inc;
    logic [ede_pkg::COST_W-1:0] fin_dist;

    // Handshake and opcode decode
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_accept   = i_in.valid && i_in.ready;
    assign is_load     = (i_in.operation == ede_pkg::OP_LOAD);
    assign is_query    = (i_in.operation == ede_pkg::OP_QUERY);
    assign is_finish   = (i_in.operation == ede_pkg::OP_FINISH);
    assign out_free    = !r_out_valid || o_out.ready;
    assign qc_inc      = r_qc + ede_pkg::LEN_W'(1);

    assign o_out.valid    = r_out_valid;
    assign o_out.distance = r_out_dist;
    assign o_out.status   = r_out_status;

    // Shared cell unit: match keeps the diagonal, else one plus the smallest neighbor
    always_comb begin
        up       = r_first ? ede_pkg::COST_W'(r_j) : r_row_rd;
        min_du   = (r_diag < up) ? r_diag : up;
        min_all  = (min_du < r_left) ? min_du : r_left;
        cell_val = (r_ref_rd == r_q) ? r_diag : (min_all + ede_pkg::COST_W'(1));
        fin_dist = (r_qc == '0) ? ede_pkg::COST_W'(r_ref_len) : r_row_rd;
    end

    // Address and write strobes of both memories
    always_comb begin
        row_rd_addr = '0;
        row_we      = 1'b0;
        row_wr_addr = '0;
        row_wr_data = ede_pkg::COST_W'(qc_inc);
        ref_rd_addr = '0;
        ref_we      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (is_finish) begin
                    row_rd_addr = ede_pkg::ROW_AW'(r_ref_len);
                end
                if (in_accept && is_query && (r_qc != ede_pkg::LEN_W'(ede_pkg::MAX_LEN))) begin
                    row_we = 1'b1;
                end
                if (in_accept && is_load && (r_qc == '0)
                        && (r_ref_len != ede_pkg::LEN_W'(ede_pkg::MAX_LEN))) begin
                    ref_we = 1'b1;
                end
            end
            S_PRIME: begin
                row_rd_addr = ede_pkg::ROW_AW'(1);
            end
            S_CELL: begin
                row_rd_addr = ede_pkg::ROW_AW'(r_j + ede_pkg::LEN_W'(1));
                ref_rd_addr = r_j[ede_pkg::REF_AW-1:0];
                row_we      = 1'b1;
                row_wr_addr = ede_pkg::ROW_AW'(r_j);
                row_wr_data = cell_val;
            end
            S_FIN: begin
                row_rd_addr = ede_pkg::ROW_AW'(r_ref_len);
            end
            default: begin
                row_rd_addr = '0;
            end
        endcase
    end

    // Memories: one write and one registered read each cycle
    always_ff @(posedge i_clk) begin
        r_row_rd <= row_mem[row_rd_addr];
        r_ref_rd <= ref_mem[ref_rd_addr];
        if (row_we) begin
            row_mem[row_wr_addr] <= row_wr_data;
        end
        if (ref_we) begin
            ref_mem[r_ref_len[ede_pkg::REF_AW-1:0]] <= i_in.symbol;
        end
    end

    // Sequencer, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ref_len    <= '0;
            r_qc         <= '0;
            r_ovf        <= 1'b0;
            r_first      <= 1'b0;
            r_j          <= '0;
            r_q          <= '0;
            r_diag       <= '0;
            r_left       <= '0;
            r_out_valid  <= 1'b0;
            r_out_dist   <= '0;
            r_out_status <= ede_pkg::ST_OK;
        end else begin
            // Drop the result once taken; a finish that reloads it sets it below
            if (o_out.valid && o_out.ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (is_load) begin
                            if (r_qc == '0) begin
                                if (r_ref_len == ede_pkg::LEN_W'(ede_pkg::MAX_LEN)) begin
                                    r_ovf <= 1'b1;
                                end else begin
                                    r_ref_len <= r_ref_len + ede_pkg::LEN_W'(1);
                                end
                            end
                        end else if (is_query) begin
                            if (r_qc == ede_pkg::LEN_W'(ede_pkg::MAX_LEN)) begin
                                r_ovf <= 1'b1;
                            end else begin
                                r_first <= (r_qc == '0);
                                r_qc    <= qc_inc;
                                r_q     <= i_in.symbol;
                                r_state <= S_PRIME;
                            end
                        end else if (is_finish) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_PRIME: begin
                    // Old row[0] becomes the first diagonal; new row[0] is the left
                    r_diag  <= r_first ? '0 : r_row_rd;
                    r_left  <= ede_pkg::COST_W'(r_qc);
                    r_j     <= ede_pkg::LEN_W'(1);
                    r_state <= (r_ref_len == '0) ? S_IDLE : S_CELL;
                end
                S_CELL: begin
                    // Advance one cell per cycle
                    r_diag <= up;
                    r_left <= cell_val;
                    r_j    <= r_j + ede_pkg::LEN_W'(1);
                    if (r_j == r_ref_len) begin
                        r_state <= S_IDLE;
                    end
                end
                S_FIN: begin
                    // Hold until the output register can take the result
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_dist   <= ede_pkg::DIST_W'(fin_dist);
                        r_out_status <= r_ovf ? ede_pkg::ST_OVERFLOW : ede_pkg::ST_OK;
                        r_ref_len    <= '0;
                        r_qc         <= '0;
                        r_ovf        <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Counters never pass the string limit
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ref_len <= ede_pkg::LEN_W'(ede_pkg::MAX_LEN))
        && (r_qc <= ede_pkg::LEN_W'(ede_pkg::MAX_LEN)))
        else $error("length counter beyond limit");

    // The cell index stays inside the reference
    a_cell_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL) |-> ((r_j != '0) && (r_j <= r_ref_len)))
        else $error("cell index out of range");

    // A query in progress always has a nonzero query count
    a_query_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PRIME) || (r_state == S_CELL)) |-> (r_qc != '0))
        else $error("query sweep without query count");

    // A new result leaves the pair cleared
    a_clear_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ((r_qc == '0) && (r_ref_len == '0) && !r_ovf))
        else $error("pair not cleared after finish");

endmodule

[test/edit_distance_engine_test.sv]
// Testbench for edit_distance_engine: streams reference/query pairs and checks each distance.
// Depends on ede_pkg, ede_in_if, ede_out_if and the engine RTL; predicts with its own DP row.
module edit_distance_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ede_pkg::OP_W-1:0] OP_UNUSED    = 2'd3;
    localparam int                       RANDOM_ITEMS = 580;
    localparam int                       DRAIN_CYCLES = ede_pkg::MAX_LEN + 16;
    localparam int unsigned              CYCLE_LIMIT  = 400000;
    localparam int                       HOLD_CYCLES  = 1500;

    typedef struct {
        logic [ede_pkg::DIST_W-1:0] distance;
        logic                       status;
    } t_distance_result;

    // Shadow of the engine: reference string, rolling cost row, pending distances
    class edit_distance_tracker;
        logic [ede_pkg::SYM_W-1:0] ref_sym [ede_pkg::MAX_LEN];
        int                        cost_row [ede_pkg::MAX_LEN+1];
        int                        ref_len = 0;
        int                        query_len = 0;
        bit                        overflow = 0;
        t_distance_result          pending_distances [$];
        int                        checked = 0;
        int                        errors = 0;
        int                        n_load = 0, n_query = 0, n_finish = 0, n_unused = 0;
        int                        overflow_results = 0, longest_ref = 0, longest_query = 0;

        // Update the shadow state for one accepted input transaction
        function void accept_symbol(logic [ede_pkg::OP_W-1:0] op,
                                    logic [ede_pkg::SYM_W-1:0] sym);
            int               j, diag, up, cost;
            t_distance_result r;
            case (op)
                ede_pkg::OP_LOAD: begin
                    n_load++;
                    if (query_len == 0) begin
                        if (ref_len >= ede_pkg::MAX_LEN) begin
                            overflow = 1;
                        end else begin
                            ref_sym[ref_len] = sym;
                            ref_len++;
                        end
                    end
                end
                ede_pkg::OP_QUERY: begin
                    n_query++;
                    if (query_len >= ede_pkg::MAX_LEN) begin
                        overflow = 1;
                    end else begin
                        // seed the row on the first query symbol
                        if (query_len == 0) begin
                            for (j = 0; j <= ref_len; j++) cost_row[j] = j;
                        end
                        query_len++;
                        diag = cost_row[0];
                        cost_row[0] = query_len;
                        for (j = 1; j <= ref_len; j++) begin
                            up = cost_row[j];
                            if (ref_sym[j-1] == sym) begin
                                cost = diag;
                            end else begin
                                cost = diag;
                                if (up < cost) cost = up;
                                if (cost_row[j-1] < cost) cost = cost_row[j-1];
                                cost = cost + 1;
                            end
                            diag = up;
                            cost_row[j] = cost;
                        end
                    end
                end
                ede_pkg::OP_FINISH: begin
                    n_finish++;
                    r.distance = ede_pkg::DIST_W'((query_len == 0) ? ref_len
                                                                   : cost_row[ref_len]);
                    r.status   = overflow ? ede_pkg::ST_OVERFLOW : ede_pkg::ST_OK;
                    pending_distances = {pending_distances, r};
                    if (overflow) overflow_results++;
                    if (ref_len > longest_ref) longest_ref = ref_len;
                    if (query_len > longest_query) longest_query = query_len;
                    ref_len = 0;
                    query_len = 0;
                    overflow = 0;
                end
                default: n_unused++;
            endcase
        endfunction

        // Compare one accepted result with the oldest pending distance
        function void check_distance(logic [ede_pkg::DIST_W-1:0] got_dist, logic got_status);
            t_distance_result r;
            checked++;
            if (pending_distances.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result %0d: unexpected, distance %0d status %0d",
                             checked, got_dist, got_status);
                return;
            end
            r = pending_distances.pop_front();
            if (r.distance !== got_dist || r.status !== got_status) begin
                errors++;
                if (errors <= 10)
                    $display("result %0d: distance exp %0d got %0d, status exp %0d got %0d",
                             checked, r.distance, got_dist, r.status, got_status);
            end
        endfunction

        function int outstanding();
            return pending_distances.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ede_in_if  in_ch ();
    ede_out_if out_ch ();

    edit_distance_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    edit_distance_tracker      tracker;
    int unsigned               cycle_count = 0;
    int                        sent_count = 0;
    int                        burst_left = 0;
    logic [ede_pkg::SYM_W-1:0] alphabet [4];
    int                        alpha_size = 0;

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Hold all inputs at known values from time zero
    initial begin
        in_ch.valid     = 1'b0;
        in_ch.operation = ede_pkg::OP_LOAD;
        in_ch.symbol    = '0;
        out_ch.ready    = 1'b0;
    end

    // Watchdog: give up after a generous cycle budget
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Check every result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            tracker.check_distance(out_ch.distance, out_ch.status);
    end

    // Receiver: windows of free flow, random and heavy stalls, one long hold-off
    initial begin
        int window, mode;
        bit held;
        held = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!held && tracker.checked >= 12) begin
                held = 1;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    out_ch.ready = 1'b0;
                end
            end
            mode   = $urandom_range(0, 3);
            window = $urandom_range(16, 160);
            repeat (window) begin
                @(negedge i_clk);
                case (mode)
                    0: out_ch.ready = 1'b1;
                    1: out_ch.ready = 1'($urandom_range(0, 1));
                    2: out_ch.ready = ($urandom_range(0, 7) == 0);
                    default: out_ch.ready = ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Sender pacing: bursts with gaps, now and then a long stretch without gaps
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10);
            repeat (gap) begin
                @(negedge i_clk);
                in_ch.valid     = 1'b0;
                in_ch.operation = ede_pkg::OP_W'($urandom_range(0, 3));
                in_ch.symbol    = ede_pkg::SYM_W'($urandom_range(0, 255));
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
    endtask

    // Offer one transaction and hold it until the engine takes it
    task automatic send(logic [ede_pkg::OP_W-1:0] op, logic [ede_pkg::SYM_W-1:0] sym);
        pace();
        @(negedge i_clk);
        in_ch.valid     = 1'b1;
        in_ch.operation = op;
        in_ch.symbol    = sym;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        tracker.accept_symbol(op, sym);
        sent_count++;
    endtask

    function automatic logic [ede_pkg::SYM_W-1:0] rand_byte();
        return ede_pkg::SYM_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [ede_pkg::SYM_W-1:0] pick_symbol();
        if (alpha_size == 0) return rand_byte();
        return alphabet[$urandom_range(0, alpha_size - 1)];
    endfunction

    // One pair: mostly well-formed, sometimes noise with an optional finish
    task automatic run_pair();
        int                        ref_n, qry_n, k, noise_n;
        bit                        edited;
        logic [ede_pkg::SYM_W-1:0] ref_str [$];
        logic [ede_pkg::SYM_W-1:0] sym;
        alpha_size = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
        for (k = 0; k < 4; k++) alphabet[k] = rand_byte();
        if ($urandom_range(0, 9) < 8) begin
            ref_n  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
            qry_n  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
            edited = 1'($urandom_range(0, 1));
            for (k = 0; k < ref_n; k++) begin
                sym = pick_symbol();
                ref_str = {ref_str, sym};
                send(ede_pkg::OP_LOAD, sym);
            end
            // edited copies keep distances small and exercise the match path
            for (k = 0; k < qry_n; k++) begin
                if (edited && k < ref_n && $urandom_range(0, 3) != 0) sym = ref_str[k];
                else sym = pick_symbol();
                send(ede_pkg::OP_QUERY, sym);
            end
            send(ede_pkg::OP_FINISH, rand_byte());
        end else begin
            noise_n = $urandom_range(1, 12);
            repeat (noise_n) send(ede_pkg::OP_W'($urandom_range(0, 3)), pick_symbol());
            if ($urandom_range(0, 2) != 0) send(ede_pkg::OP_FINISH, rand_byte());
        end
    endtask

    // Strings past MAX_LEN: over-long reference, or over-long query on an empty reference
    task automatic run_long_pair(bit long_ref);
        send(ede_pkg::OP_FINISH, rand_byte());
        if (long_ref) begin
            repeat (ede_pkg::MAX_LEN + 3) send(ede_pkg::OP_LOAD, rand_byte());
            repeat (2) send(ede_pkg::OP_QUERY, rand_byte());
        end else begin
            repeat (ede_pkg::MAX_LEN + 3) send(ede_pkg::OP_QUERY, rand_byte());
        end
        send(ede_pkg::OP_FINISH, rand_byte());
    endtask

    // Main sequence: reset, directed pairs, random pairs, drain, verdict
    initial begin
        int pair_idx, start_count, long_items, directed_items;
        tracker = new();
        pair_idx   = 0;
        long_items = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty pair, unused code, empty query, empty reference
        send(ede_pkg::OP_FINISH, 8'h00);
        send(OP_UNUSED, 8'hFF);
        send(ede_pkg::OP_LOAD, 8'h00);
        send(ede_pkg::OP_LOAD, 8'hFF);
        send(ede_pkg::OP_LOAD, 8'hA5);
        send(ede_pkg::OP_FINISH, 8'hFF);
        send(ede_pkg::OP_QUERY, 8'hFF);
        send(ede_pkg::OP_FINISH, 8'h00);
        // mixed pair with a load arriving after the query began
        send(ede_pkg::OP_LOAD, 8'h5A);
        send(ede_pkg::OP_LOAD, 8'hFF);
        send(ede_pkg::OP_QUERY, 8'h5A);
        send(ede_pkg::OP_QUERY, 8'h00);
        send(ede_pkg::OP_LOAD, 8'h11);
        send(ede_pkg::OP_QUERY, 8'hFF);
        send(OP_UNUSED, 8'h00);
        send(ede_pkg::OP_FINISH, 8'h5A);
        // identical strings give zero
        send(ede_pkg::OP_LOAD, 8'h01);
        send(ede_pkg::OP_LOAD, 8'h02);
        send(ede_pkg::OP_LOAD, 8'h03);
        send(ede_pkg::OP_QUERY, 8'h01);
        send(ede_pkg::OP_QUERY, 8'h02);
        send(ede_pkg::OP_QUERY, 8'h03);
        send(ede_pkg::OP_FINISH, 8'h00);
        directed_items = sent_count;

        while (sent_count - long_items - directed_items < RANDOM_ITEMS) begin
            if (pair_idx == 8 || pair_idx == 20) begin
                start_count = sent_count;
                run_long_pair(pair_idx == 8);
                long_items += sent_count - start_count;
            end
            run_pair();
            pair_idx++;
        end
        send(ede_pkg::OP_FINISH, rand_byte());
        @(negedge i_clk);
        in_ch.valid = 1'b0;

        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d loads, %0d queries, %0d finishes, %0d unused codes; %0d results",
                 tracker.n_load, tracker.n_query, tracker.n_finish, tracker.n_unused,
                 tracker.checked);
        $display("longest reference %0d, longest query %0d, %0d overflow results, %0d errors",
                 tracker.longest_ref, tracker.longest_query, tracker.overflow_results,
                 tracker.errors);
        if (tracker.outstanding() != 0)
            $display("%0d distances never came out", tracker.outstanding());
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
